// File: rtl/core/jsu_pkg.sv
`timescale 1ns / 1ps

package jsu_pkg;

    // decoder modes
    typedef enum logic [2:0] {
        M_WAIT     = 3'd0,
        M_BODY     = 3'd1,
        M_ESC      = 3'd2,
        M_HEX      = 3'd3,
        M_PEND     = 3'd4,
        M_PEND_BS  = 3'd5,
        M_PEND_HEX = 3'd6,
        M_BADHEX   = 3'd7
    } t_mode;

    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_NO_QUOTE   = 3'd1,
        ERR_UNTERM_STR = 3'd2,
        ERR_UNTERM_ESC = 3'd3,
        ERR_SHORT_U    = 3'd4,
        ERR_BAD_HEX    = 3'd5,
        ERR_BAD_ESC    = 3'd6
    } t_err;

    // what the second part of a job emits
    typedef enum logic [1:0] {
        K_NONE = 2'd0,
        K_BYTE = 2'd1,
        K_CODE = 2'd2,
        K_DONE = 2'd3
    } t_kind;

    // one decoded input item: optional pending surrogate, then one main action
    typedef struct packed {
        logic        has_pend;
        logic [15:0] pend;
        t_kind       kind;
        logic [20:0] value;
        t_err        err;
    } t_job;

    localparam logic [15:0] SURR_HI_MIN = 16'hD800;
    localparam logic [15:0] SURR_HI_MAX = 16'hDBFF;
    localparam logic [15:0] SURR_LO_MIN = 16'hDC00;
    localparam logic [15:0] SURR_LO_MAX = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE   = 21'h10000;

    localparam logic [7:0] LEAD2     = 8'hC0;
    localparam logic [7:0] LEAD3     = 8'hE0;
    localparam logic [7:0] LEAD4     = 8'hF0;
    localparam logic [7:0] CONT      = 8'h80;
    localparam logic [7:0] CONT_MASK = 8'h3F;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_U      = 8'h75;

endpackage

// File: rtl/core/jsu_front.sv
`timescale 1ns / 1ps

module jsu_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_in_byte,
    input  logic             i_end_of_input,
    output logic             o_push,
    output jsu_pkg::t_job    o_job
);

    jsu_pkg::t_mode r_mode, n_mode;
    logic [1:0]     r_cnt, n_cnt;
    logic [15:0]    r_acc, n_acc;
    logic [15:0]    r_pend, n_pend;

    logic        hex_ok;
    logic [3:0]  hex_v;
    logic [15:0] acc_next;
    logic        acc_hi, acc_lo;
    logic        esc_hit;
    logic [7:0]  esc_byte;
    logic        is_quote, is_bs, is_u;
    logic [20:0] pair_cp;
    jsu_pkg::t_job job;

    assign is_quote = (i_in_byte == jsu_pkg::CH_QUOTE);
    assign is_bs    = (i_in_byte == jsu_pkg::CH_BSLASH);
    assign is_u     = (i_in_byte == jsu_pkg::CH_U);

    always_comb begin
        hex_ok = 1'b1;
        hex_v  = 4'd0;
        if (i_in_byte >= 8'h30 && i_in_byte <= 8'h39) begin
            hex_v = 4'(i_in_byte - 8'h30);
        end else if (i_in_byte >= 8'h61 && i_in_byte <= 8'h66) begin
            hex_v = 4'(i_in_byte - 8'h57);
        end else if (i_in_byte >= 8'h41 && i_in_byte <= 8'h46) begin
            hex_v = 4'(i_in_byte - 8'h37);
        end else begin
            hex_ok = 1'b0;
        end
    end

    // simple escapes
    always_comb begin
        esc_hit  = 1'b1;
        esc_byte = 8'h00;
        unique case (i_in_byte)
            jsu_pkg::CH_QUOTE:  esc_byte = jsu_pkg::CH_QUOTE;
            jsu_pkg::CH_BSLASH: esc_byte = jsu_pkg::CH_BSLASH;
            jsu_pkg::CH_SLASH:  esc_byte = jsu_pkg::CH_SLASH;
            8'h62:              esc_byte = 8'h08;
            8'h66:              esc_byte = 8'h0C;
            8'h6E:              esc_byte = 8'h0A;
            8'h72:              esc_byte = 8'h0D;
            8'h74:              esc_byte = 8'h09;
            default:            esc_hit  = 1'b0;
        endcase
    end

    assign acc_next = {r_acc[11:0], hex_v};
    assign acc_hi   = (acc_next >= jsu_pkg::SURR_HI_MIN) && (acc_next <= jsu_pkg::SURR_HI_MAX);
    assign acc_lo   = (acc_next >= jsu_pkg::SURR_LO_MIN) && (acc_next <= jsu_pkg::SURR_LO_MAX);
    assign pair_cp  = jsu_pkg::SUPP_BASE + {1'b0, r_pend[9:0], acc_next[9:0]};

    // next state
    always_comb begin
        n_mode = r_mode;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_pend = r_pend;
        if (i_accept) begin
            if (i_end_of_input) begin
                if (r_mode != jsu_pkg::M_WAIT) begin
                    n_mode = jsu_pkg::M_WAIT;
                    n_cnt  = '0;
                    n_acc  = '0;
                    n_pend = '0;
                end
            end else begin
                unique case (r_mode)
                    jsu_pkg::M_WAIT: begin
                        if (is_quote) begin
                            n_mode = jsu_pkg::M_BODY;
                        end else begin
                            n_cnt  = '0;
                            n_acc  = '0;
                            n_pend = '0;
                        end
                    end
                    jsu_pkg::M_BODY, jsu_pkg::M_PEND: begin
                        if (is_quote) begin
                            n_mode = jsu_pkg::M_WAIT;
                        end else if (is_bs) begin
                            n_mode = (r_mode == jsu_pkg::M_PEND) ? jsu_pkg::M_PEND_BS
                                                                 : jsu_pkg::M_ESC;
                        end else begin
                            n_mode = jsu_pkg::M_BODY;
                        end
                    end
                    jsu_pkg::M_ESC, jsu_pkg::M_PEND_BS: begin
                        if (is_u) begin
                            n_mode = (r_mode == jsu_pkg::M_PEND_BS) ? jsu_pkg::M_PEND_HEX
                                                                    : jsu_pkg::M_HEX;
                            n_cnt  = '0;
                            n_acc  = '0;
                        end else if (esc_hit) begin
                            n_mode = jsu_pkg::M_BODY;
                        end else begin
                            n_mode = jsu_pkg::M_WAIT;
                            n_cnt  = '0;
                            n_acc  = '0;
                            n_pend = '0;
                        end
                    end
                    jsu_pkg::M_HEX, jsu_pkg::M_PEND_HEX: begin
                        if (!hex_ok) begin
                            if (r_cnt == 2'd3) begin
                                n_mode = jsu_pkg::M_WAIT;
                                n_cnt  = '0;
                                n_acc  = '0;
                                n_pend = '0;
                            end else begin
                                n_cnt  = r_cnt + 2'd1;
                                n_mode = jsu_pkg::M_BADHEX;
                            end
                        end else if (r_cnt != 2'd3) begin
                            n_cnt = r_cnt + 2'd1;
                            n_acc = acc_next;
                        end else begin
                            n_cnt = '0;
                            n_acc = '0;
                            if (r_mode == jsu_pkg::M_PEND_HEX && acc_lo) begin
                                n_pend = '0;
                                n_mode = jsu_pkg::M_BODY;
                            end else if (acc_hi) begin
                                n_pend = acc_next;
                                n_mode = jsu_pkg::M_PEND;
                            end else begin
                                n_mode = jsu_pkg::M_BODY;
                            end
                        end
                    end
                    jsu_pkg::M_BADHEX: begin
                        if (r_cnt == 2'd3) begin
                            n_mode = jsu_pkg::M_WAIT;
                            n_cnt  = '0;
                            n_acc  = '0;
                            n_pend = '0;
                        end else begin
                            n_cnt = r_cnt + 2'd1;
                        end
                    end
                    default: n_mode = r_mode;
                endcase
            end
        end
    end

    // job for the back end
    always_comb begin
        job      = '0;
        job.pend = r_pend;
        if (i_end_of_input) begin
            job.kind = jsu_pkg::K_DONE;
            unique case (r_mode)
                jsu_pkg::M_WAIT:                     job.kind = jsu_pkg::K_NONE;
                jsu_pkg::M_BODY, jsu_pkg::M_PEND:    job.err  = jsu_pkg::ERR_UNTERM_STR;
                jsu_pkg::M_ESC, jsu_pkg::M_PEND_BS:  job.err  = jsu_pkg::ERR_UNTERM_ESC;
                default:                             job.err  = jsu_pkg::ERR_SHORT_U;
            endcase
        end else begin
            unique case (r_mode)
                jsu_pkg::M_WAIT: begin
                    if (!is_quote) begin
                        job.kind = jsu_pkg::K_DONE;
                        job.err  = jsu_pkg::ERR_NO_QUOTE;
                    end
                end
                jsu_pkg::M_BODY, jsu_pkg::M_PEND: begin
                    if (r_mode == jsu_pkg::M_PEND && !is_bs) begin
                        job.has_pend = 1'b1;
                    end
                    if (is_quote) begin
                        job.kind = jsu_pkg::K_DONE;
                    end else if (!is_bs) begin
                        job.kind  = jsu_pkg::K_BYTE;
                        job.value = {13'd0, i_in_byte};
                    end
                end
                jsu_pkg::M_ESC, jsu_pkg::M_PEND_BS: begin
                    if (!is_u) begin
                        job.has_pend = (r_mode == jsu_pkg::M_PEND_BS);
                        if (esc_hit) begin
                            job.kind  = jsu_pkg::K_BYTE;
                            job.value = {13'd0, esc_byte};
                        end else begin
                            job.kind = jsu_pkg::K_DONE;
                            job.err  = jsu_pkg::ERR_BAD_ESC;
                        end
                    end
                end
                jsu_pkg::M_HEX, jsu_pkg::M_PEND_HEX: begin
                    if (r_cnt == 2'd3) begin
                        if (!hex_ok) begin
                            job.kind = jsu_pkg::K_DONE;
                            job.err  = jsu_pkg::ERR_BAD_HEX;
                        end else if (r_mode == jsu_pkg::M_PEND_HEX && acc_lo) begin
                            job.kind  = jsu_pkg::K_CODE;
                            job.value = pair_cp;
                        end else begin
                            job.has_pend = (r_mode == jsu_pkg::M_PEND_HEX);
                            if (!acc_hi) begin
                                job.kind  = jsu_pkg::K_CODE;
                                job.value = {5'd0, acc_next};
                            end
                        end
                    end
                end
                jsu_pkg::M_BADHEX: begin
                    if (r_cnt == 2'd3) begin
                        job.kind = jsu_pkg::K_DONE;
                        job.err  = jsu_pkg::ERR_BAD_HEX;
                    end
                end
                default: job.kind = jsu_pkg::K_NONE;
            endcase
        end
    end

    assign o_job  = job;
    assign o_push = i_accept && (job.has_pend || job.kind != jsu_pkg::K_NONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= jsu_pkg::M_WAIT;
            r_cnt  <= '0;
            r_acc  <= '0;
            r_pend <= '0;
        end else begin
            r_mode <= n_mode;
            r_cnt  <= n_cnt;
            r_acc  <= n_acc;
            r_pend <= n_pend;
        end
    end

endmodule

// File: rtl/core/jsu_queue.sv
`timescale 1ns / 1ps

module jsu_queue #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  jsu_pkg::t_job i_job,
    output logic          o_ready,
    input  logic          i_pop,
    output logic          o_valid,
    output jsu_pkg::t_job o_job
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    jsu_pkg::t_job r_mem [DEPTH];
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_count, n_count;
    logic          do_push, do_pop;

    assign o_ready = (r_count != CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

// File: rtl/core/jsu_back.sv
`timescale 1ns / 1ps

module jsu_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  jsu_pkg::t_job i_q_job,
    output logic          o_q_pop,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic [7:0]    o_out_byte,
    output logic          o_byte_valid,
    output logic          o_string_done,
    output logic [2:0]    o_error_code
);

    function automatic logic [2:0] utf8_len(input logic [20:0] code);
        logic [2:0] n;
        if (code < 21'h80) begin
            n = 3'd1;
        end else if (code < 21'h800) begin
            n = 3'd2;
        end else if (code < jsu_pkg::SUPP_BASE) begin
            n = 3'd3;
        end else begin
            n = 3'd4;
        end
        return n;
    endfunction

    // byte idx of an n-byte encoding
    function automatic logic [7:0] utf8_byte(input logic [20:0] code, input logic [2:0] n,
                                             input logic [1:0] idx);
        logic [7:0] b;
        logic [2:0] rem;
        rem = n - 3'd1 - {1'b0, idx};
        b   = 8'h00;
        if (idx == 2'd0) begin
            unique case (n)
                3'd1:    b = {1'b0, code[6:0]};
                3'd2:    b = jsu_pkg::LEAD2 | {3'd0, code[10:6]};
                3'd3:    b = jsu_pkg::LEAD3 | {4'd0, code[15:12]};
                default: b = jsu_pkg::LEAD4 | {5'd0, code[20:18]};
            endcase
        end else begin
            unique case (rem)
                3'd0:    b = jsu_pkg::CONT | ({2'd0, code[5:0]} & jsu_pkg::CONT_MASK);
                3'd1:    b = jsu_pkg::CONT | ({2'd0, code[11:6]} & jsu_pkg::CONT_MASK);
                default: b = jsu_pkg::CONT | ({2'd0, code[17:12]} & jsu_pkg::CONT_MASK);
            endcase
        end
        return b;
    endfunction

    logic          r_busy;
    jsu_pkg::t_job r_job;
    logic          r_in_pend;
    logic [1:0]    r_idx;

    logic          r_ovalid;
    logic [7:0]    r_obyte;
    logic          r_obv;
    logic          r_odone;
    logic [2:0]    r_oerr;

    logic [7:0]    c_byte;
    logic          c_bv, c_done, c_last;
    logic [2:0]    c_err;
    logic [2:0]    main_len;
    logic          adv, load;

    assign main_len = utf8_len(r_job.value);
    assign adv      = r_busy && (!r_ovalid || i_out_ready);

    always_comb begin
        c_byte = 8'h00;
        c_bv   = 1'b0;
        c_done = 1'b0;
        c_err  = jsu_pkg::ERR_NONE;
        c_last = 1'b1;
        if (r_in_pend) begin
            c_byte = utf8_byte({5'd0, r_job.pend}, 3'd3, r_idx);
            c_bv   = 1'b1;
            c_last = (r_idx == 2'd2) && (r_job.kind == jsu_pkg::K_NONE);
        end else begin
            unique case (r_job.kind)
                jsu_pkg::K_BYTE: begin
                    c_byte = r_job.value[7:0];
                    c_bv   = 1'b1;
                end
                jsu_pkg::K_CODE: begin
                    c_byte = utf8_byte(r_job.value, main_len, r_idx);
                    c_bv   = 1'b1;
                    c_last = ({1'b0, r_idx} == main_len - 3'd1);
                end
                jsu_pkg::K_DONE: begin
                    c_done = 1'b1;
                    c_err  = r_job.err;
                end
                default: c_last = 1'b1;
            endcase
        end
    end

    assign load    = i_q_valid && (!r_busy || (adv && c_last));
    assign o_q_pop = load;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_job <= i_q_job;
        end
        if (adv) begin
            r_obyte <= c_byte;
            r_obv   <= c_bv;
            r_odone <= c_done;
            r_oerr  <= c_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_in_pend <= 1'b0;
            r_idx     <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            if (adv) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            if (load) begin
                r_busy    <= 1'b1;
                r_in_pend <= i_q_job.has_pend;
                r_idx     <= '0;
            end else if (adv) begin
                if (c_last) begin
                    r_busy <= 1'b0;
                end else if (r_in_pend && r_idx == 2'd2) begin
                    r_in_pend <= 1'b0;
                    r_idx     <= '0;
                end else begin
                    r_idx <= r_idx + 2'd1;
                end
            end
        end
    end

    assign o_out_valid   = r_ovalid;
    assign o_out_byte    = r_obyte;
    assign o_byte_valid  = r_obv;
    assign o_string_done = r_odone;
    assign o_error_code  = r_oerr;

endmodule

// File: rtl/core/json_string_unescape_utf8.sv
`timescale 1ns / 1ps

// json string unescaper: feed the raw bytes of one json string literal, opening quote
// first, one request per cycle; the block returns the decoded string one byte per
// result, with \uXXXX escapes encoded as utf-8 and surrogate pairs merged into four-byte
// characters. the closing quote gives a result with string_done set and byte_valid
// clear; an error gives a single result with string_done set and a nonzero error_code,
// after which the block waits for a new opening quote and the consumer should drop the
// bytes it already received for that string. an input request is taken every cycle
// while the job queue (QUEUE_DEPTH entries) has room; each request yields zero to six
// results, and the back end sends one result per cycle while i_out_ready is high, so
// a burst of multi-byte characters holds the input only until the queue drains. the
// first result passes through the queue, the job register and the output register.
module json_string_unescape_utf8 #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_input,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_byte_valid,
    output logic       o_string_done,
    output logic [2:0] o_error_code
);

    // front: decode state machine, one request per cycle while the queue has room,
    // emits a job when the request produces output
    logic          in_accept;
    logic          f_push;
    jsu_pkg::t_job f_job;

    // queue between front and back
    logic          q_ready;
    logic          q_valid;
    logic          q_pop;
    jsu_pkg::t_job q_job;

    assign o_in_ready = q_ready;
    assign in_accept  = i_in_valid && q_ready;

    jsu_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (in_accept),
        .i_in_byte      (i_in_byte),
        .i_end_of_input (i_end_of_input),
        .o_push         (f_push),
        .o_job          (f_job)
    );

    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_job   (f_job),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    // back: expands each job into result bytes through an output register
    jsu_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_job       (q_job),
        .o_q_pop       (q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_byte    (o_out_byte),
        .o_byte_valid  (o_byte_valid),
        .o_string_done (o_string_done),
        .o_error_code  (o_error_code)
    );

`ifndef SYNTHESIS
    // the front only produces jobs for accepted requests, which needs queue room
    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        f_push |-> q_ready)
        else $error("job pushed into a full queue");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("job popped from an empty queue");

    // an error result always closes the string and carries no byte
    a_err_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_error_code != jsu_pkg::ERR_NONE) |-> (o_string_done && !o_byte_valid))
        else $error("error result without string_done");

    a_done_no_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_string_done) |-> !o_byte_valid)
        else $error("string_done result carries a byte");
`endif

endmodule
